// File: rtl/bcu_pkg.sv
// Shared types and constants for the binomial coefficient unit.
`timescale 1ns / 1ps

package bcu_pkg;

   // Field widths of the request and response words.
   localparam int CNT_W  = 6;
   localparam int COEF_W = 59;

   // Largest n for which the coefficient is computed rather than saturated.
   localparam logic [CNT_W-1:0] MAX_N = 6'd62;

   // Step index width: the number of steps never exceeds MAX_N / 2.
   localparam int K_W = $clog2(MAX_N / 2 + 1);

   // Width of the running product times the next factor.
   localparam int PROD_W = 64;

   // Quotient bits retired by the divider in each cycle.
   localparam int DIV_DIGIT_W = 8;

   typedef struct packed {
      logic [CNT_W-1:0] total_count;
      logic [CNT_W-1:0] choose_count;
   } req_type;

   typedef struct packed {
      logic [COEF_W-1:0] coefficient;
      logic              out_of_range;
   } rsp_type;

endpackage

// File: rtl/bcu_div.sv
// Iterative exact divider of a 64-bit dividend by a small step index.
`timescale 1ns / 1ps

module bcu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bcu_pkg::PROD_W-1:0]  dividend,
   input  logic [bcu_pkg::K_W-1:0]     divisor,
   output logic                        done,
   output logic [bcu_pkg::PROD_W-1:0]  quotient
);

   localparam int DIG     = bcu_pkg::DIV_DIGIT_W;
   localparam int PW      = bcu_pkg::PROD_W;
   localparam int KW      = bcu_pkg::K_W;
   localparam int STEPS   = PW / DIG;
   localparam int STEP_W  = $clog2(STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic [KW-1:0]     rem_ff, rem_in;
   logic [PW-1:0]     num_ff, num_in;
   logic [PW-1:0]     quot_ff, quot_in;
   logic [KW-1:0]     div_ff, div_in;

   logic [KW-1:0]     rem_step;
   logic [DIG-1:0]    qbits;
   logic [KW:0]       trial;

   // Restoring division, DIG bits per cycle; the remainder stays below the divisor.
   always_comb begin
      rem_step = rem_ff;
      qbits    = '0;
      trial    = '0;
      for (int i = 0; i < DIG; i++) begin
         trial = {rem_step, num_ff[PW-1-i]};
         if (trial >= {1'b0, div_ff}) begin
            trial          = trial - {1'b0, div_ff};
            qbits[DIG-1-i] = 1'b1;
         end
         rem_step = trial[KW-1:0];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         num_in   = dividend;
         quot_in  = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         num_in   = num_ff << DIG;
         quot_in  = {quot_ff[PW-DIG-1:0], qbits};
         rem_in   = rem_step;
         count_in = count_ff + {{(STEP_W-1){1'b0}}, 1'b1};
         if (count_ff == STEP_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: rtl/binomial_coefficient_unit.sv
// Top level of the binomial coefficient unit: sequencer, multiplier, divider and output register.
`timescale 1ns / 1ps

// Usage:
// A request word carries n (total_count) and m (choose_count). Each request
// yields one response word with n choose m and an out_of_range flag that is
// set, with a zero coefficient, when m exceeds n. An n above MAX_N with m not
// exceeding n gives a saturated all-ones coefficient.
// The block works on one request at a time: req_ready is high only while the
// sequencer is idle. For r = min(m, n - m) the work is r multiply-divide steps;
// each step passes through the 59 x 6 multiplier and then the divider, which
// retires eight quotient bits a cycle while it runs. The trivial cases skip
// the steps; the worst case is r = 31. The next request can be taken in the
// same cycle that the response becomes valid.
// The response sits in an output register, so a stalled receiver does not
// block the next request; the sequencer only waits at its final step if the
// previous response has still not been taken.
// Synchronous reset returns the sequencer to idle and drops rsp_valid.
module binomial_coefficient_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bcu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bcu_pkg::rsp_type rsp_data
);

   localparam int CW = bcu_pkg::CNT_W;
   localparam int QW = bcu_pkg::COEF_W;
   localparam int KW = bcu_pkg::K_W;
   localparam int PW = bcu_pkg::PROD_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    n_ff, n_in;
   logic [KW-1:0]    r_ff, r_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [QW-1:0]    prod_ff, prod_in;
   bcu_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bcu_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [CW-1:0]    diff;
   logic [CW-1:0]    r_sel;
   logic [CW:0]      fac_wide;
   logic [PW-1:0]    prod_ext;
   logic [PW-1:0]    fac_ext;
   logic [PW-1:0]    mult;
   logic             div_start;
   logic             div_done;
   logic [PW-1:0]    div_quot;

   assign diff  = req_data.total_count - req_data.choose_count;
   assign r_sel = (req_data.choose_count < diff) ? req_data.choose_count : diff;

   // Next factor is n - k + 1.
   assign fac_wide = ({1'b0, n_ff} - {{(CW + 1 - KW){1'b0}}, k_ff})
                     + {{CW{1'b0}}, 1'b1};
   assign prod_ext = {{(PW - QW){1'b0}}, prod_ff};
   assign fac_ext  = {{(PW - CW){1'b0}}, fac_wide[CW-1:0]};
   assign mult     = prod_ext * fac_ext;

   bcu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mult),
      .divisor  (k_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in    = req_data.total_count;
               r_in    = r_sel[KW-1:0];
               k_in    = {{(KW-1){1'b0}}, 1'b1};
               prod_in = {{(QW-1){1'b0}}, 1'b1};
               if (req_data.choose_count > req_data.total_count) begin
                  res_in.coefficient  = '0;
                  res_in.out_of_range = 1'b1;
                  state_in            = ST_DONE;
               end else if (req_data.total_count > bcu_pkg::MAX_N) begin
                  res_in.coefficient  = {QW{1'b1}};
                  res_in.out_of_range = 1'b0;
                  state_in            = ST_DONE;
               end else if (r_sel == '0) begin
                  res_in.coefficient  = {{(QW-1){1'b0}}, 1'b1};
                  res_in.out_of_range = 1'b0;
                  state_in            = ST_DONE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               prod_in = div_quot[QW-1:0];
               if (k_ff == r_ff) begin
                  res_in.coefficient  = div_quot[QW-1:0];
                  res_in.out_of_range = 1'b0;
                  state_in            = ST_DONE;
               end else begin
                  k_in     = k_ff + {{(KW-1){1'b0}}, 1'b1};
                  state_in = ST_MUL;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/bcu_checker.sv
// Port-level checks for the binomial coefficient unit, bound to the top level.
`timescale 1ns / 1ps

module bcu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input bcu_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bcu_pkg::rsp_type rsp_data
);

   // A response word that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed or dropped");

   // A flagged response always carries a zero coefficient.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |-> rsp_data.coefficient == '0)
      else $error("out_of_range response with nonzero coefficient");

   // The unit holds one request at a time, so it is busy right after an accept.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a previous one is in progress");

   // Reset leaves no response pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind binomial_coefficient_unit bcu_checker u_bcu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
